@@ src/scpr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpr_pkg: shared definitions for the second-chance page replacement engine
// Default sizes, register layout, result field widths and sequencer states.
// ----------------------------------------------------------------------------
package scpr_pkg;

   localparam int FRAMES_DEFAULT    = 16;
   localparam int PAGE_BITS_DEFAULT = 16;

   // frames_in_use register
   localparam int              FIU_W     = 5;
   localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;

   // result field widths
   localparam int FRAME_OUT_W = 4;
   localparam int FAULT_W     = 32;

   typedef enum logic [1:0] {
      ST_IDLE,    // waiting for a reference
      ST_SEARCH,  // one frame compared per cycle
      ST_SCAN,    // clock hand sweep, clearing reference bits
      ST_LOAD     // victim frame read back and replaced
   } state_type;

endpackage

@@ src/second_chance_page_replacement.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// second_chance_page_replacement: clock page replacement engine
// A page reference is taken with start while busy is low. A single comparator
// walks the frame table one entry a cycle (lowest frame wins a hit); on a
// miss the clock hand sweeps the frames in use, clearing reference bits, until
// it meets a clear bit, and the page is loaded there. The frame table has a
// registered read port and the clock hand advances one frame per cycle. Each
// result is shown for a single cycle with rsp_valid and cannot be held off by
// the receiver. csr_wdata is to be written only while the engine is idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module second_chance_page_replacement #(
   parameter int FRAMES    = scpr_pkg::FRAMES_DEFAULT,
   parameter int PAGE_BITS = scpr_pkg::PAGE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_we,
   input  logic [scpr_pkg::FIU_W-1:0]       csr_wdata,
   // reference input
   input  logic                             start,
   output logic                             busy,
   input  logic [PAGE_BITS-1:0]             req_page_number,
   input  logic                             req_last_ref,
   // result
   output logic                             rsp_valid,
   output logic                             rsp_was_hit,
   output logic [scpr_pkg::FRAME_OUT_W-1:0] rsp_frame_used,
   output logic                             rsp_evicted_valid,
   output logic [PAGE_BITS-1:0]             rsp_evicted_page,
   output logic [scpr_pkg::FAULT_W-1:0]     rsp_total_faults,
   output logic                             rsp_run_done
);

   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

   scpr_pkg::state_type state_ff, state_in;

   logic [scpr_pkg::FIU_W-1:0] frames_in_use_ff, frames_in_use_in;

   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic                 last_ff, last_in;
   logic [IDX_W-1:0]     last_idx_ff, last_idx_in;
   logic [IDX_W-1:0]     scan_ff, scan_in;
   logic [IDX_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]     victim_ptr_ff, victim_ptr_in;
   logic [scpr_pkg::FAULT_W-1:0] fault_count_ff, fault_count_in;
   logic [FRAMES-1:0]    valid_ff, valid_in;
   logic [FRAMES-1:0]    ref_ff, ref_in;

   // frame table
   logic [PAGE_BITS-1:0] frame_page_mem [FRAMES];
   logic [PAGE_BITS-1:0] rd_data_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 mem_we;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_was_hit_ff, rsp_was_hit_in;
   logic [scpr_pkg::FRAME_OUT_W-1:0] rsp_frame_used_ff, rsp_frame_used_in;
   logic                             rsp_evicted_valid_ff, rsp_evicted_valid_in;
   logic [PAGE_BITS-1:0]             rsp_evicted_page_ff, rsp_evicted_page_in;
   logic [scpr_pkg::FAULT_W-1:0]     rsp_total_faults_ff, rsp_total_faults_in;
   logic                             rsp_run_done_ff, rsp_run_done_in;

   logic             accept;
   logic             hit_found;
   logic             miss_found;
   logic [IDX_W-1:0] lim_idx;
   logic [IDX_W-1:0] ptr_next;

   assign busy   = (state_ff != scpr_pkg::ST_IDLE);
   assign accept = start && !busy;

   // last frame index taking part, register clamped to 1..FRAMES
   always_comb begin
      int lim;
      if (frames_in_use_ff == '0) begin
         lim = 0;
      end else if (int'(frames_in_use_ff) > FRAMES) begin
         lim = FRAMES - 1;
      end else begin
         lim = int'(frames_in_use_ff) - 1;
      end
      lim_idx = IDX_W'(lim);
   end

   assign frames_in_use_in = csr_we ? csr_wdata : frames_in_use_ff;

   assign hit_found  = (state_ff == scpr_pkg::ST_SEARCH) && cmp_vld_ff &&
                       valid_ff[cmp_idx_ff] && (rd_data_ff == page_ff);
   assign miss_found = (state_ff == scpr_pkg::ST_SEARCH) && cmp_vld_ff &&
                       !hit_found && (cmp_idx_ff == last_idx_ff);

   assign ptr_next = (victim_ptr_ff == last_idx_ff) ? '0 : victim_ptr_ff + IDX_W'(1);
   assign rd_addr  = (state_ff == scpr_pkg::ST_SCAN) ? victim_ptr_ff : scan_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scpr_pkg::ST_IDLE: begin
            if (start) state_in = scpr_pkg::ST_SEARCH;
         end
         scpr_pkg::ST_SEARCH: begin
            priority if (hit_found) state_in = scpr_pkg::ST_IDLE;
            else if (miss_found)    state_in = scpr_pkg::ST_SCAN;
            else                    state_in = scpr_pkg::ST_SEARCH;
         end
         scpr_pkg::ST_SCAN: begin
            if (!ref_ff[victim_ptr_ff]) state_in = scpr_pkg::ST_LOAD;
         end
         scpr_pkg::ST_LOAD: begin
            state_in = scpr_pkg::ST_IDLE;
         end
         default: state_in = scpr_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      page_in              = page_ff;
      last_in              = last_ff;
      last_idx_in          = last_idx_ff;
      scan_in              = scan_ff;
      cmp_idx_in           = cmp_idx_ff;
      cmp_vld_in           = cmp_vld_ff;
      victim_ptr_in        = victim_ptr_ff;
      fault_count_in       = fault_count_ff;
      valid_in             = valid_ff;
      ref_in               = ref_ff;
      mem_we               = 1'b0;
      rsp_valid_in         = 1'b0;
      rsp_was_hit_in       = rsp_was_hit_ff;
      rsp_frame_used_in    = rsp_frame_used_ff;
      rsp_evicted_valid_in = rsp_evicted_valid_ff;
      rsp_evicted_page_in  = rsp_evicted_page_ff;
      rsp_total_faults_in  = rsp_total_faults_ff;
      rsp_run_done_in      = rsp_run_done_ff;

      unique case (state_ff)
         scpr_pkg::ST_IDLE: begin
            if (accept) begin
               page_in     = req_page_number;
               last_in     = req_last_ref;
               last_idx_in = lim_idx;
               scan_in     = '0;
               cmp_vld_in  = 1'b0;
               // hand left beyond the frames in use by a register change
               if (victim_ptr_ff > lim_idx) victim_ptr_in = '0;
            end
         end
         scpr_pkg::ST_SEARCH: begin
            cmp_idx_in = scan_ff;
            cmp_vld_in = 1'b1;
            if (scan_ff != last_idx_ff) scan_in = scan_ff + IDX_W'(1);
            if (hit_found) begin
               ref_in[cmp_idx_ff]   = 1'b1;
               rsp_valid_in         = 1'b1;
               rsp_was_hit_in       = 1'b1;
               rsp_frame_used_in    = scpr_pkg::FRAME_OUT_W'(cmp_idx_ff);
               rsp_evicted_valid_in = 1'b0;
               rsp_evicted_page_in  = '0;
               rsp_total_faults_in  = fault_count_ff;
               rsp_run_done_in      = last_ff;
               if (last_ff) begin
                  valid_in       = '0;
                  ref_in         = '0;
                  victim_ptr_in  = '0;
                  fault_count_in = '0;
               end
            end else if (miss_found) begin
               if (fault_count_ff != '1) fault_count_in = fault_count_ff + 32'd1;
            end
         end
         scpr_pkg::ST_SCAN: begin
            if (ref_ff[victim_ptr_ff]) begin
               ref_in[victim_ptr_ff] = 1'b0;
               victim_ptr_in         = ptr_next;
            end
         end
         scpr_pkg::ST_LOAD: begin
            mem_we                = 1'b1;
            valid_in[victim_ptr_ff] = 1'b1;
            ref_in[victim_ptr_ff]   = 1'b1;
            victim_ptr_in         = ptr_next;
            rsp_valid_in          = 1'b1;
            rsp_was_hit_in        = 1'b0;
            rsp_frame_used_in     = scpr_pkg::FRAME_OUT_W'(victim_ptr_ff);
            rsp_evicted_valid_in  = valid_ff[victim_ptr_ff];
            rsp_evicted_page_in   = valid_ff[victim_ptr_ff] ? rd_data_ff : '0;
            rsp_total_faults_in   = fault_count_ff;
            rsp_run_done_in       = last_ff;
            if (last_ff) begin
               valid_in       = '0;
               ref_in         = '0;
               victim_ptr_in  = '0;
               fault_count_in = '0;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // frame table, registered read
   always_ff @(posedge clock) begin
      if (mem_we) frame_page_mem[victim_ptr_ff] <= page_ff;
      rd_data_ff <= frame_page_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= scpr_pkg::ST_IDLE;
         frames_in_use_ff <= scpr_pkg::FIU_RESET;
         valid_ff         <= '0;
         ref_ff           <= '0;
         victim_ptr_ff    <= '0;
         fault_count_ff   <= '0;
         cmp_vld_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         frames_in_use_ff <= frames_in_use_in;
         valid_ff         <= valid_in;
         ref_ff           <= ref_in;
         victim_ptr_ff    <= victim_ptr_in;
         fault_count_ff   <= fault_count_in;
         cmp_vld_ff       <= cmp_vld_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff              <= page_in;
      last_ff              <= last_in;
      last_idx_ff          <= last_idx_in;
      scan_ff              <= scan_in;
      cmp_idx_ff           <= cmp_idx_in;
      rsp_was_hit_ff       <= rsp_was_hit_in;
      rsp_frame_used_ff    <= rsp_frame_used_in;
      rsp_evicted_valid_ff <= rsp_evicted_valid_in;
      rsp_evicted_page_ff  <= rsp_evicted_page_in;
      rsp_total_faults_ff  <= rsp_total_faults_in;
      rsp_run_done_ff      <= rsp_run_done_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_was_hit       = rsp_was_hit_ff;
   assign rsp_frame_used    = rsp_frame_used_ff;
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_page  = rsp_evicted_page_ff;
   assign rsp_total_faults  = rsp_total_faults_ff;
   assign rsp_run_done      = rsp_run_done_ff;

endmodule
